// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/ceu_pkg.sv -----
`default_nettype none
package ceu_pkg;

   typedef enum logic [1:0] {
      OP_RAISE        = 2'd0,
      OP_HARD_RESET   = 2'd1,
      OP_SOFT_RESET   = 2'd2,
      OP_STATUS_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      VC_GENERAL     = 2'd0,
      VC_INTERRUPT   = 2'd1,
      VC_TLB_REFILL  = 2'd2,
      VC_CACHE_ERROR = 2'd3
   } vclass_type;

   // ExcCode values that touch more than Cause/EPC
   localparam logic [4:0] EXC_MOD        = 5'd1;
   localparam logic [4:0] EXC_TLB_LOAD   = 5'd2;
   localparam logic [4:0] EXC_TLB_STORE  = 5'd3;
   localparam logic [4:0] EXC_ADDR_LOAD  = 5'd4;
   localparam logic [4:0] EXC_ADDR_STORE = 5'd5;
   localparam logic [4:0] EXC_CPU        = 5'd11;

   // configuration register indexes
   localparam logic [1:0] CSR_EXCEPTION_BASE     = 2'd0;
   localparam logic [1:0] CSR_BOOT_VECTOR        = 2'd1;
   localparam logic [1:0] CSR_SPECIAL_INT_VECTOR = 2'd2;

   localparam logic [31:0] DEFAULT_BASE       = 32'h8000_0000;
   localparam logic [31:0] RESET_BOOT_VECTOR  = 32'hbfc0_0000;
   localparam logic [31:0] BASE_MASK          = 32'hffff_f000;
   localparam logic [31:0] CACHE_ERR_MASK     = 32'h1fff_f000;
   localparam logic [31:0] KSEG1_BASE         = 32'ha000_0000;
   localparam logic [31:0] OFF_GENERAL        = 32'h0000_0180;
   localparam logic [31:0] OFF_INTERRUPT      = 32'h0000_0200;
   localparam logic [31:0] OFF_CACHE_ERR      = 32'h0000_0100;
   localparam logic [31:0] OFF_BEV_GENERAL    = 32'h0000_0380;
   localparam logic [31:0] OFF_BEV_INTERRUPT  = 32'h0000_0400;
   localparam logic [31:0] OFF_BEV_TLB_REFILL = 32'h0000_0200;
   localparam logic [31:0] OFF_BEV_CACHE_ERR  = 32'h0000_0300;
   localparam logic [31:0] DELAY_SLOT_STEP    = 32'd4;

   typedef struct packed {
      op_type      op;
      logic [31:0] current_pc;
      logic        branch_delay;
      logic [4:0]  exception_code;
      vclass_type  vector_class;
      logic [31:0] exception_info;
      logic        write_exl;
      logic        write_erl;
      logic        write_bev;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [31:0] epc_value;
      logic [31:0] error_epc_value;
      logic [31:0] bad_address;
      logic [18:0] bad_page_pair;
      logic [4:0]  cause_code;
      logic        cause_delay_slot;
      logic [1:0]  cause_coprocessor;
      logic        exl_out;
      logic        erl_out;
      logic        bev_out;
      logic        link_cleared;
   } rsp_type;

   typedef struct packed {
      logic        enable;
      logic [1:0]  index;
      logic [31:0] data;
   } csr_write_type;

endpackage
`default_nettype wire

// ----- rtl/ceu_vector.sv -----
`default_nettype none
module ceu_vector (
   input  wire ceu_pkg::vclass_type vector_class,
   input  wire                      nested,
   input  wire                      bev,
   input  wire                      special_int_vector,
   input  wire [31:0]               exception_base,
   input  wire [31:0]               boot_vector,
   output logic [31:0]              vector
);

   logic [31:0] base_raw;
   logic [31:0] base;
   logic [31:0] general;

   always_comb begin
      base_raw = exception_base & ceu_pkg::BASE_MASK;
      // zero EBase falls back to the default kseg0 base
      base     = (base_raw == 32'd0) ? ceu_pkg::DEFAULT_BASE : base_raw;
      general  = bev ? boot_vector + ceu_pkg::OFF_BEV_GENERAL
                     : base + ceu_pkg::OFF_GENERAL;
      case (vector_class)
         ceu_pkg::VC_INTERRUPT: begin
            if (!special_int_vector) begin
               vector = general;
            end else begin
               vector = bev ? boot_vector + ceu_pkg::OFF_BEV_INTERRUPT
                            : base + ceu_pkg::OFF_INTERRUPT;
            end
         end
         ceu_pkg::VC_TLB_REFILL: begin
            if (nested) begin
               vector = general;
            end else begin
               vector = bev ? boot_vector + ceu_pkg::OFF_BEV_TLB_REFILL : base;
            end
         end
         ceu_pkg::VC_CACHE_ERROR: begin
            // cache errors run uncached through kseg1
            vector = bev ? boot_vector + ceu_pkg::OFF_BEV_CACHE_ERR
                         : ceu_pkg::KSEG1_BASE | (base & ceu_pkg::CACHE_ERR_MASK)
                           | ceu_pkg::OFF_CACHE_ERR;
         end
         default: begin
            vector = general;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/ceu_state.sv -----
`default_nettype none
module ceu_state (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    step,
   input  wire ceu_pkg::req_type  item,
   input  wire ceu_pkg::csr_write_type csr,
   output ceu_pkg::rsp_type       result
);

   // CP0 state
   logic        exl_ff, exl_in;
   logic        erl_ff, erl_in;
   logic        bev_ff, bev_in;
   logic [4:0]  code_ff, code_in;
   logic        bd_ff, bd_in;
   logic [1:0]  ce_ff, ce_in;
   logic [31:0] epc_ff, epc_in;
   logic [31:0] error_epc_ff, error_epc_in;
   logic [31:0] badva_ff, badva_in;
   logic [18:0] vpn2_ff, vpn2_in;
   // configuration
   logic [31:0] ebase_ff, ebase_in;
   logic [31:0] boot_ff, boot_in;
   logic        iv_ff, iv_in;

   logic [31:0] vector;
   logic [31:0] pc_adj;
   logic [31:0] next_pc;
   logic        cleared;

   ceu_vector u_vector (
      .vector_class       (item.vector_class),
      .nested             (exl_ff),
      .bev                (bev_ff),
      .special_int_vector (iv_ff),
      .exception_base     (ebase_ff),
      .boot_vector        (boot_ff),
      .vector             (vector)
   );

   always_comb begin
      exl_in       = exl_ff;
      erl_in       = erl_ff;
      bev_in       = bev_ff;
      code_in      = code_ff;
      bd_in        = bd_ff;
      ce_in        = ce_ff;
      epc_in       = epc_ff;
      error_epc_in = error_epc_ff;
      badva_in     = badva_ff;
      vpn2_in      = vpn2_ff;
      ebase_in     = ebase_ff;
      boot_in      = boot_ff;
      iv_in        = iv_ff;
      next_pc      = item.current_pc;
      cleared      = 1'b0;
      // point back at the branch when the fault sits in its delay slot
      pc_adj       = item.branch_delay ? item.current_pc - ceu_pkg::DELAY_SLOT_STEP
                                       : item.current_pc;

      if (step) begin
         case (item.op)
            ceu_pkg::OP_RAISE: begin
               cleared = 1'b1;
               code_in = item.exception_code;
               if (!exl_ff) begin
                  bd_in  = item.branch_delay;
                  epc_in = pc_adj;
               end
               if (item.exception_code == ceu_pkg::EXC_CPU) begin
                  ce_in = item.exception_info[1:0];
               end
               if (item.exception_code inside {ceu_pkg::EXC_ADDR_LOAD,
                                               ceu_pkg::EXC_ADDR_STORE}) begin
                  badva_in = item.exception_info;
               end
               if (item.exception_code inside {ceu_pkg::EXC_MOD, ceu_pkg::EXC_TLB_LOAD,
                                               ceu_pkg::EXC_TLB_STORE}) begin
                  badva_in = item.exception_info;
                  vpn2_in  = item.exception_info[31:13];
               end
               next_pc = vector;
               exl_in  = 1'b1;
            end
            ceu_pkg::OP_HARD_RESET: begin
               exl_in       = 1'b0;
               erl_in       = 1'b1;
               bev_in       = 1'b1;
               code_in      = 5'd0;
               bd_in        = 1'b0;
               ce_in        = 2'd0;
               epc_in       = 32'd0;
               error_epc_in = 32'd0;
               badva_in     = 32'd0;
               vpn2_in      = 19'd0;
               ebase_in     = ceu_pkg::DEFAULT_BASE;
               iv_in        = 1'b0;
               cleared      = 1'b1;
               next_pc      = boot_ff;
            end
            ceu_pkg::OP_SOFT_RESET: begin
               error_epc_in = pc_adj;
               bev_in       = 1'b1;
               erl_in       = 1'b1;
               if (!exl_ff) begin
                  bd_in = 1'b0;
               end
               cleared      = 1'b1;
               next_pc      = boot_ff;
            end
            default: begin
               exl_in = item.write_exl;
               erl_in = item.write_erl;
               bev_in = item.write_bev;
            end
         endcase
      end else if (csr.enable) begin
         case (csr.index)
            ceu_pkg::CSR_EXCEPTION_BASE:     ebase_in = csr.data;
            ceu_pkg::CSR_BOOT_VECTOR:        boot_in  = csr.data;
            ceu_pkg::CSR_SPECIAL_INT_VECTOR: iv_in    = csr.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exl_ff       <= 1'b0;
         erl_ff       <= 1'b1;
         bev_ff       <= 1'b1;
         code_ff      <= 5'd0;
         bd_ff        <= 1'b0;
         ce_ff        <= 2'd0;
         epc_ff       <= 32'd0;
         error_epc_ff <= 32'd0;
         badva_ff     <= 32'd0;
         vpn2_ff      <= 19'd0;
         ebase_ff     <= ceu_pkg::DEFAULT_BASE;
         boot_ff      <= ceu_pkg::RESET_BOOT_VECTOR;
         iv_ff        <= 1'b0;
      end else begin
         exl_ff       <= exl_in;
         erl_ff       <= erl_in;
         bev_ff       <= bev_in;
         code_ff      <= code_in;
         bd_ff        <= bd_in;
         ce_ff        <= ce_in;
         epc_ff       <= epc_in;
         error_epc_ff <= error_epc_in;
         badva_ff     <= badva_in;
         vpn2_ff      <= vpn2_in;
         ebase_ff     <= ebase_in;
         boot_ff      <= boot_in;
         iv_ff        <= iv_in;
      end
   end

   always_comb begin
      result.next_pc           = next_pc;
      result.epc_value         = epc_in;
      result.error_epc_value   = error_epc_in;
      result.bad_address       = badva_in;
      result.bad_page_pair     = vpn2_in;
      result.cause_code        = code_in;
      result.cause_delay_slot  = bd_in;
      result.cause_coprocessor = ce_in;
      result.exl_out           = exl_in;
      result.erl_out           = erl_in;
      result.bev_out           = bev_in;
      result.link_cleared      = cleared;
   end

endmodule
`default_nettype wire

// ----- rtl/cpu_exception_entry_unit_core.sv -----
// Exception-entry unit of a MIPS32 coprocessor 0.
// Request channel (req_valid/req_stall/req_data): one word per event: raise an
//   exception, hard reset, soft reset or a Status write of EXL/ERL/BEV.
// Response channel (rsp_valid/rsp_stall/rsp_data): exactly one word per event,
//   carrying the fetch address (handler or boot vector) and the CP0 state
//   after the event.
// Config port (csr_write_enable/csr_index/csr_write_data): EBase, boot vector
//   and Cause.IV; write only while no event is in flight.
// Path: the request word is accepted into the input register, then passes
//   through vector select and state update into the response register.
// Throughput: one event per cycle while the response is not stalled.
// Stall: a stalled response holds; the input register still takes one more
//   word, then req_stall rises until the response is taken.
// Reset: clears the valid bits of both pipeline registers and returns CP0 state
//   and config to their power-up values (BEV=1, ERL=1, boot vector 0xBFC00000).
`default_nettype none
`include "assert_macros.svh"
module cpu_exception_entry_unit_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire ceu_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ceu_pkg::rsp_type       rsp_data,
   input  wire                    csr_write_enable,
   input  wire [1:0]              csr_index,
   input  wire [31:0]             csr_write_data
);

   // input register
   logic             in_valid_ff, in_valid_in;
   ceu_pkg::req_type in_data_ff;
   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   ceu_pkg::rsp_type rsp_data_ff;

   ceu_pkg::rsp_type      result;
   ceu_pkg::csr_write_type csr;
   logic                  advance;

   // terms for the checks at the end
   logic                  rsp_blocked;
   logic                  raise_step;
   logic                  hard_step;
   logic                  clear_step;
   logic                  hard_ok;

   // advance the held word when the response slot is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   // hold off the sender only while the input register cannot move on
   assign req_stall = in_valid_ff && !advance;

   assign csr.enable = csr_write_enable;
   assign csr.index  = csr_index;
   assign csr.data   = csr_write_data;

   ceu_state u_state (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .csr    (csr),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         // drop the response once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rsp_blocked = rsp_valid_ff && rsp_stall;
   assign raise_step  = advance && (in_data_ff.op == ceu_pkg::OP_RAISE);
   assign hard_step   = advance && (in_data_ff.op == ceu_pkg::OP_HARD_RESET);
   assign clear_step  = advance && (in_data_ff.op != ceu_pkg::OP_STATUS_WRITE);
   assign hard_ok     = rsp_data_ff.erl_out && rsp_data_ff.bev_out && !rsp_data_ff.exl_out;

   `ASSERT_CLK(a_stall_cause, clock, reset, req_stall |-> rsp_blocked, "stray input stall")
   `ASSERT_CLK(a_raise_sets_exl, clock, reset, raise_step |=> rsp_data_ff.exl_out, "EXL not set")
   `ASSERT_CLK(a_hard_reset_status, clock, reset, hard_step |=> hard_ok, "bad hard reset status")
   `ASSERT_CLK(a_link_set, clock, reset, clear_step |=> rsp_data.link_cleared, "link not cleared")

endmodule
`default_nettype wire
